/* hw/rtl/rmv_pkg.sv */
// rmv_pkg: types and constants shared by the running mean / variance unit.
// Used by rmv_shared_alu and running_mean_variance_unit; depends on nothing.
package rmv_pkg;

  // shared unit operation codes
  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  localparam int STEP_W = 7;   // holds up to 127 steps

  localparam logic [STEP_W-1:0] MEAN_DIV_STEPS = 7'd32;
  localparam logic [STEP_W-1:0] MUL_STEPS      = 7'd32;
  localparam logic [STEP_W-1:0] VAR_DIV_STEPS  = 7'd64;

  localparam logic [31:0] FULL_COUNT = 32'hFFFF_FFFF;

  // request into the shared unit
  typedef struct packed {
    logic              start;
    logic              op;
    logic [63:0]       a;      // dividend, or multiplier in the low half
    logic [31:0]       b;      // divisor or multiplicand
    logic [STEP_W-1:0] steps;
  } alu_req_t;

  // response from the shared unit
  typedef struct packed {
    logic        done;   // one-cycle pulse, res valid with it
    logic [63:0] res;    // quotient or product
  } alu_rsp_t;

endpackage

/* hw/rtl/rmv_shared_alu.sv */
// rmv_shared_alu: one 33-bit adder reused for restoring division and
// shift-add multiplication, one step per cycle. Depends on rmv_pkg.
module rmv_shared_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rmv_pkg::alu_req_t req,
  output rmv_pkg::alu_rsp_t rsp
);

  logic                       busy_r;
  logic                       done_r;
  logic [rmv_pkg::STEP_W-1:0] cnt_r;
  logic                       op_r;
  logic [31:0]                hi_r;    // remainder, or product high half
  logic [63:0]                lo_r;    // quotient, or multiplier / product low half
  logic [31:0]                opnd_r;  // divisor or multiplicand

  logic        is_div;
  logic [32:0] add_a;
  logic [32:0] add_b;
  logic [33:0] add_res;
  logic        no_borrow;
  logic [32:0] mul_sum;
  logic [31:0] hi_nxt;
  logic [63:0] lo_nxt;

  // shared adder: subtract for division, add for multiplication
  assign is_div  = (op_r == rmv_pkg::OP_DIV);
  assign add_a   = is_div ? {hi_r, lo_r[63]} : {1'b0, hi_r};
  assign add_b   = {1'b0, opnd_r};
  assign add_res = {1'b0, add_a} + {1'b0, (is_div ? ~add_b : add_b)} + {33'b0, is_div};

  assign no_borrow = add_res[33];
  assign mul_sum   = lo_r[0] ? add_res[32:0] : add_a;

  // one step of the selected operation
  always_comb begin
    if (is_div) begin
      hi_nxt = no_borrow ? add_res[31:0] : add_a[31:0];
      lo_nxt = {lo_r[62:0], no_borrow};
    end else begin
      hi_nxt = mul_sum[32:1];
      lo_nxt = {lo_r[63:32], mul_sum[0], lo_r[31:1]};
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator words
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      opnd_r <= req.b;
      hi_r   <= '0;
      lo_r   <= req.a;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = is_div ? lo_r : {hi_r, lo_r[31:0]};

endmodule

/* hw/rtl/running_mean_variance_unit.sv */
// running_mean_variance_unit: Welford running mean, sum of squared deviations
// and sample variance in fixed point. Depends on rmv_pkg and rmv_shared_alu.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_stall, in_sample, in_restart    | to unit
//   out     | out_valid, out_stall, out_sample_count,      | from unit
//           | out_running_mean, out_squared_dev_sum,       |
//           | out_variance, out_variance_valid, out_overflow
//
// Each word runs 32 mean division steps, 32 multiply steps and 64 variance
// division steps, all on the one shared adder, plus the sequencing states.
// Below a count of two the variance division is skipped; a dropped sample
// skips the first two.
// in_stall is high from the accepting edge until the sequencer is idle again.
// The result sits in an output register, so a stalled result does not block
// the next word's work; only the hand-off of the following result waits.
// Reset clears the statistics and the sequencer; no clearing pass.
module running_mean_variance_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_sample,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_sample_count,
  output logic signed [31:0] out_running_mean,
  output logic [63:0] out_squared_dev_sum,
  output logic [63:0] out_variance,
  output logic        out_variance_valid,
  output logic        out_overflow
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MDIV   = 3'd1;
  localparam logic [2:0] ST_MUL_GO = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_VAR_GO = 3'd4;
  localparam logic [2:0] ST_VDIV   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]  state_r;
  logic [31:0] count_r;
  logic [31:0] mean_r;
  logic [63:0] dev_r;
  logic        ovf_r;
  logic        varv_r;
  logic [63:0] var_r;
  logic [31:0] sample_r;
  logic        d1_neg_r;
  logic [31:0] abs_d1_r;
  logic [31:0] n_r;

  logic        out_valid_r;
  logic [31:0] out_count_r;
  logic [31:0] out_mean_r;
  logic [63:0] out_dev_r;
  logic [63:0] out_var_r;
  logic        out_varv_r;
  logic        out_ovf_r;

  rmv_pkg::alu_req_t req;
  rmv_pkg::alu_rsp_t rsp;

  logic        in_acc;
  logic [31:0] cnt_eff;
  logic [31:0] mean_eff;
  logic [63:0] dev_eff;
  logic        cnt_full;
  logic [32:0] d1;
  logic [32:0] abs_d1;
  logic [33:0] delta;
  logic [33:0] mean_upd;
  logic [32:0] d2;
  logic [32:0] abs_d2;
  logic [64:0] dev_sum;
  logic        var_ok;
  logic        out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // restart clears before the sample is added
  assign cnt_eff  = in_restart ? 32'd0 : count_r;
  assign mean_eff = in_restart ? 32'd0 : mean_r;
  assign dev_eff  = in_restart ? 64'd0 : dev_r;
  assign cnt_full = (cnt_eff == rmv_pkg::FULL_COUNT);

  // first deviation, taken as a magnitude for the divider
  assign d1     = {in_sample[31], in_sample} - {mean_eff[31], mean_eff};
  assign abs_d1 = d1[32] ? (33'd0 - d1) : d1;

  // mean step from the truncated quotient
  assign delta    = d1_neg_r ? (34'd0 - {2'b0, rsp.res[31:0]}) : {2'b0, rsp.res[31:0]};
  assign mean_upd = {{2{mean_r[31]}}, mean_r} + delta;

  // second deviation against the new mean
  assign d2     = {sample_r[31], sample_r} - {mean_r[31], mean_r};
  assign abs_d2 = d2[32] ? (33'd0 - d2) : d2;

  // sum of squared deviations, product truncated to Q48.16
  assign dev_sum = {1'b0, dev_r} + {17'd0, rsp.res[63:16]};

  assign var_ok = (count_r >= 32'd2);

  // shared unit requests
  always_comb begin
    req       = '0;
    req.op    = rmv_pkg::OP_DIV;
    req.steps = rmv_pkg::MEAN_DIV_STEPS;
    req.a     = {abs_d1[31:0], 32'd0};
    req.b     = cnt_eff + 32'd1;
    case (state_r)
      ST_IDLE: begin
        req.start = in_acc && !cnt_full;
      end
      ST_MUL_GO: begin
        req.start = 1'b1;
        req.op    = rmv_pkg::OP_MUL;
        req.steps = rmv_pkg::MUL_STEPS;
        req.a     = {32'd0, abs_d1_r};
        req.b     = abs_d2[31:0];
      end
      ST_VAR_GO: begin
        req.start = var_ok;
        req.steps = rmv_pkg::VAR_DIV_STEPS;
        req.a     = dev_r;
        req.b     = count_r - 32'd1;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  rmv_shared_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // sequencer and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      mean_r  <= '0;
      dev_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            count_r <= cnt_eff;
            mean_r  <= mean_eff;
            dev_r   <= dev_eff;
            state_r <= cnt_full ? ST_VAR_GO : ST_MDIV;
          end
        end
        ST_MDIV: begin
          if (rsp.done) begin
            mean_r  <= mean_upd[31:0];
            count_r <= n_r;
            state_r <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (rsp.done) begin
            dev_r   <= dev_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dev_sum[63:0];
            state_r <= ST_VAR_GO;
          end
        end
        ST_VAR_GO: begin
          state_r <= var_ok ? ST_VDIV : ST_FIN;
        end
        ST_VDIV: begin
          if (rsp.done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
      d1_neg_r <= d1[32];
      abs_d1_r <= abs_d1[31:0];
      n_r      <= cnt_eff + 32'd1;
      ovf_r    <= cnt_full;
    end else if (state_r == ST_MUL && rsp.done) begin
      ovf_r <= ovf_r | dev_sum[64];
    end
    if (state_r == ST_VAR_GO) begin
      varv_r <= var_ok;
      var_r  <= '0;
    end else if (state_r == ST_VDIV && rsp.done) begin
      var_r <= rsp.res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= count_r;
      out_mean_r  <= mean_r;
      out_dev_r   <= dev_r;
      out_var_r   <= var_r;
      out_varv_r  <= varv_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_count    = out_count_r;
  assign out_running_mean    = out_mean_r;
  assign out_squared_dev_sum = out_dev_r;
  assign out_variance        = out_var_r;
  assign out_variance_valid  = out_varv_r;
  assign out_overflow        = out_ovf_r;

endmodule

/* hw/rtl/rmv_checker.sv */
// rmv_checker: port-level checks on running_mean_variance_unit, and the bind
// that attaches them. Sees only the top level's ports.
module rmv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic signed [31:0] in_sample,
  input logic        in_restart,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_sample_count,
  input logic signed [31:0] out_running_mean,
  input logic [63:0] out_squared_dev_sum,
  input logic [63:0] out_variance,
  input logic        out_variance_valid,
  input logic        out_overflow
);

  // a word in work blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_count)
      && $stable(out_squared_dev_sum) && $stable(out_variance)
      && $stable(out_running_mean)))
    else $error("stalled result word changed");

  // variance flag follows the count
  a_varv_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_variance_valid == (out_sample_count >= 32'd2)))
    else $error("variance_valid disagrees with sample_count");

  // invalid variance reads as zero
  a_var_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_variance_valid) |-> (out_variance == 64'd0))
    else $error("variance nonzero while invalid");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for running_mean_variance_unit, with a queue-fed driver,
// a clocked monitor and a Welford statistics predictor. Depends on rmv_pkg and the RTL.
module tb;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_WORDS = 1920;
  localparam int CALM_WORDS   = 150;
  localparam int MAX_PRINTS   = 40;

  // statistics carried by one result word
  typedef struct {
    logic [31:0]        count;
    logic signed [31:0] mean;
    logic [63:0]        dev_sum;
    logic [63:0]        variance;
    logic               var_ok;
    logic               ovf;
  } stats_t;

  // one pending input word
  typedef struct {
    logic signed [31:0] sample;
    logic               restart;
    bit                 drain;  // hold it back until all results are in
    bit                 quiet;  // no idling from here on
  } word_t;

  // flavor of sample values in one random run
  typedef enum {MIX_FULL, MIX_CLUSTER, MIX_EXTREME, MIX_SMALL} mix_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] in_sample = '0;
  logic               in_restart = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [31:0]        out_sample_count;
  logic signed [31:0] out_running_mean;
  logic [63:0]        out_squared_dev_sum;
  logic [63:0]        out_variance;
  logic               out_variance_valid;
  logic               out_overflow;

  word_t  pending_words[$];
  stats_t expected_stats[$];

  // predictor state
  logic [31:0]        acc_count = '0;
  logic signed [31:0] acc_mean = '0;
  logic [63:0]        acc_dev_sum = '0;

  int  errors = 0;
  int  results_seen = 0;
  int  cycles = 0;
  logic calm = 0;
  logic send_idle = 0;
  int  send_left = 0;
  int  recv_left = 0;

  running_mean_variance_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample_count   (out_sample_count),
    .out_running_mean   (out_running_mean),
    .out_squared_dev_sum(out_squared_dev_sum),
    .out_variance       (out_variance),
    .out_variance_valid (out_variance_valid),
    .out_overflow       (out_overflow)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Welford update of the running statistics for one accepted word
  function automatic stats_t welford_step(input logic signed [31:0] sample,
                                          input logic restart);
    stats_t      r;
    longint      s, old_m, new_m, d1, d2, n;
    logic [63:0] m1, m2, inc;
    logic [64:0] wide;
    r.ovf = 1'b0;
    if (restart) begin
      acc_count = '0;
      acc_mean = '0;
      acc_dev_sum = '0;
    end
    if (acc_count == rmv_pkg::FULL_COUNT) begin
      r.ovf = 1'b1;  // sample dropped, state kept
    end else begin
      n = {32'd0, acc_count + 32'd1};
      s = sample;
      old_m = acc_mean;
      d1 = s - old_m;
      new_m = old_m + d1 / n;  // truncates toward zero
      d2 = s - new_m;
      m1 = (d1 < 0) ? -d1 : d1;
      m2 = (d2 < 0) ? -d2 : d2;
      inc = (m1 * m2) >> 16;  // Q32.32 product down to Q48.16
      wide = {1'b0, acc_dev_sum} + {1'b0, inc};
      if (wide[64]) begin
        acc_dev_sum = '1;
        r.ovf = 1'b1;
      end else begin
        acc_dev_sum = wide[63:0];
      end
      acc_count = n[31:0];
      acc_mean = new_m[31:0];
    end
    r.count = acc_count;
    r.mean = acc_mean;
    r.dev_sum = acc_dev_sum;
    r.var_ok = (acc_count >= 32'd2);
    r.variance = r.var_ok ? acc_dev_sum / {32'd0, acc_count - 32'd1} : 64'd0;
    return r;
  endfunction

  // length of a stretch without idling; now and then a long one
  function automatic int free_stretch();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(300, 1200) : $urandom_range(0, 40);
  endfunction

  task automatic flag_error(input string what);
    if (errors < MAX_PRINTS) $display("ERROR result %0d: %s", results_seen, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic add_word(input logic restart, input logic [31:0] sample, input bit drain);
    word_t w;
    w.sample = sample;
    w.restart = restart;
    w.drain = drain;
    w.quiet = 0;
    pending_words.push_back(w);
  endtask

  // sender idling: free-running bursts, so gaps land on any phase of the work
  always @(posedge clk) begin
    if (calm) begin
      send_idle <= 1'b0;
    end else if (send_left != 0) begin
      send_left <= send_left - 1;
    end else if (send_idle) begin
      send_idle <= 1'b0;
      send_left <= free_stretch();
    end else begin
      send_idle <= 1'b1;
      send_left <= $urandom_range(0, 17);
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (recv_left != 0) begin
      recv_left <= recv_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      recv_left <= free_stretch();
    end else begin
      out_stall <= 1'b1;
      recv_left <= $urandom_range(0, 17);
    end
  end

  // driver: predicts on acceptance, then offers the next pending word
  always @(posedge clk) begin : drive
    word_t w;
    logic  hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && in_stall;
      if (in_valid && !in_stall) expected_stats.push_back(welford_step(in_sample, in_restart));
      if (!hold && pending_words.size() != 0 && !send_idle &&
          (!pending_words[0].drain || expected_stats.size() == 0)) begin
        w = pending_words.pop_front();
        hold = 1'b1;
        in_sample <= w.sample;
        in_restart <= w.restart;
        if (w.quiet) calm <= 1'b1;
      end
      in_valid <= hold;
    end
  end

  // monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : watch
    stats_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        flag_error("result word with nothing expected");
      end else begin
        e = expected_stats.pop_front();
        check_field("sample_count", out_sample_count, e.count);
        check_field("running_mean", out_running_mean, e.mean);
        check_field("squared_dev_sum", out_squared_dev_sum, e.dev_sum);
        check_field("variance", out_variance, e.variance);
        check_field("variance_valid", out_variance_valid, e.var_ok);
        check_field("overflow", out_overflow, e.ovf);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int          i, k, run_len, spread;
    mix_t        mix;
    logic [31:0] center, smp;
    logic signed [31:0] nz;
    logic        rs;
    bit          dr;

    // directed: extremes, zero spread, restarts mid-run, first word without restart
    add_word(0, 32'h1234_5678, 0);
    add_word(0, 32'h7FFF_FFFF, 0);
    add_word(0, 32'h8000_0000, 0);
    add_word(0, 32'h7FFF_FFFF, 0);
    add_word(0, 32'h8000_0000, 0);
    add_word(1, 32'h8000_0000, 0);
    add_word(0, 32'h8000_0000, 0);
    add_word(0, 32'hFFFF_FFFF, 0);
    add_word(0, 32'h0000_0001, 0);
    add_word(1, 32'h7FFF_FFFF, 0);
    add_word(0, 32'h7FFF_FFFF, 0);
    add_word(0, 32'h0000_0000, 0);
    add_word(1, 32'h0000_0000, 0);
    add_word(0, 32'h0001_0000, 0);
    add_word(0, 32'h0002_0000, 0);
    add_word(0, 32'hFFFF_0000, 0);
    add_word(0, 32'h0000_FFFF, 0);
    add_word(1, 32'h5555_5555, 0);
    add_word(0, 32'hAAAA_AAAA, 0);
    add_word(1, 32'hFFFF_FFFF, 0);
    // a full count needs 2^32 samples and a saturated sum some 2^18 extreme ones,
    // so those two cases stay out of reach at this run length

    // random runs: mostly a restart followed by a stream of related samples
    dr = 1;
    while (pending_words.size() < RANDOM_WORDS) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 300) : $urandom_range(1, 60);
      mix = mix_t'($urandom_range(0, 3));
      center = $urandom;
      spread = $urandom_range(0, 31);
      for (k = 0; k < run_len && pending_words.size() < RANDOM_WORDS; k++) begin
        rs = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 59) == 0);
        case (mix)
          MIX_FULL: begin
            smp = $urandom;
          end
          MIX_CLUSTER: begin
            nz = $urandom;
            nz = nz >>> (31 - spread);
            smp = center + nz;
          end
          MIX_EXTREME: begin
            case ($urandom_range(0, 4))
              0: smp = 32'h7FFF_FFFF;
              1: smp = 32'h8000_0000;
              2: smp = 32'h0000_0000;
              3: smp = 32'hFFFF_FFFF;
              default: smp = 32'h0000_0001;
            endcase
          end
          default: begin
            smp = $urandom_range(0, 32'd1310720) - 32'd655360;  // +/- 10.0
          end
        endcase
        if ($urandom_range(0, 19) == 0) smp = $urandom;
        add_word(rs, smp, dr);
        dr = ($urandom_range(0, 199) == 0);
      end
    end
    for (i = pending_words.size() - CALM_WORDS; i < pending_words.size(); i++)
      pending_words[i].quiet = 1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
